/* sv/chc_pkg.sv */
// Shared types, constants and lookup functions for the cartridge header checker.
package chc_pkg;

  localparam int unsigned MAX_IMAGE_BYTES = 2097152;
  localparam int unsigned POS_W = $clog2(MAX_IMAGE_BYTES + 1);

  // Header addresses
  localparam logic [POS_W-1:0] LOGO_FIRST   = POS_W'(32'h104);
  localparam logic [POS_W-1:0] LOGO_LAST    = POS_W'(32'h133);
  localparam logic [POS_W-1:0] HDR_FIRST    = POS_W'(32'h134);
  localparam logic [POS_W-1:0] HDR_LAST     = POS_W'(32'h14C);
  localparam logic [POS_W-1:0] HDR_SUM_ADDR = POS_W'(32'h14D);
  localparam logic [POS_W-1:0] GLB_HI_ADDR  = POS_W'(32'h14E);
  localparam logic [POS_W-1:0] GLB_LO_ADDR  = POS_W'(32'h14F);
  localparam logic [POS_W-1:0] HEADER_END   = POS_W'(32'h150);
  localparam logic [POS_W-1:0] MODEL_ADDR   = POS_W'(32'h143);
  localparam logic [POS_W-1:0] CART_ADDR    = POS_W'(32'h147);
  localparam logic [POS_W-1:0] ROMSZ_ADDR   = POS_W'(32'h148);
  localparam logic [POS_W-1:0] RAMSZ_ADDR   = POS_W'(32'h149);
  localparam logic [POS_W-1:0] MAX_POS      = POS_W'(MAX_IMAGE_BYTES);

  localparam int unsigned LOGO_LEN = 48;
  localparam int unsigned LOGO_IDX_W = $clog2(LOGO_LEN);

  // Model byte codes and reported support codes
  localparam logic [7:0] MODEL_DUAL_BYTE  = 8'h80;
  localparam logic [7:0] MODEL_COLOR_BYTE = 8'hC0;
  localparam logic [1:0] MODEL_ORIG_ONLY  = 2'd0;
  localparam logic [1:0] MODEL_DUAL       = 2'd1;
  localparam logic [1:0] MODEL_COLOR_ONLY = 2'd2;

  localparam logic [7:0] LOGO_TABLE [LOGO_LEN] = '{
    8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
    8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
    8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
    8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
    8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
    8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
  };

  typedef struct packed {
    logic       logo_ok;
    logic       header_sum_ok;
    logic       global_sum_ok;
    logic [1:0] model_support;
    logic [7:0] cart_kind;
    logic       cart_kind_known;
    logic [7:0] rom_size_code;
    logic       rom_size_known;
    logic [7:0] ram_size_code;
    logic       image_too_short;
    logic       image_too_long;
  } result_t;

  function automatic logic cart_known(input logic [7:0] c);
    logic known;
    case (c) inside
      [8'h00:8'h03], 8'h05, 8'h06, 8'h08, 8'h09, [8'h0B:8'h0D],
      [8'h0F:8'h13], [8'h19:8'h1F], [8'hFD:8'hFF]: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

  function automatic logic rom_size_known(input logic [7:0] c);
    return (c <= 8'h06) || ((c >= 8'h52) && (c <= 8'h54));
  endfunction

  function automatic logic [1:0] model_code(input logic [7:0] m);
    logic [1:0] code;
    case (m)
      MODEL_DUAL_BYTE:  code = MODEL_DUAL;
      MODEL_COLOR_BYTE: code = MODEL_COLOR_ONLY;
      default:          code = MODEL_ORIG_ONLY;
    endcase
    return code;
  endfunction

endpackage

/* sv/chc_accum.sv */
// Per-image header state: byte position, logo match, checksums and captured codes.
module chc_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              final_i,
  output chc_pkg::result_t  res_o
);

  logic [chc_pkg::POS_W-1:0] pos_q, pos_d;
  logic        logo_match_q, logo_match_d;
  logic [7:0]  hdr_acc_q, hdr_acc_d;
  logic [15:0] glb_acc_q, glb_acc_d;
  logic [7:0]  hdr_sum_q, hdr_sum_d;
  logic [15:0] glb_sum_q, glb_sum_d;
  logic [7:0]  model_q, model_d;
  logic [7:0]  cart_q, cart_d;
  logic [7:0]  romsz_q, romsz_d;
  logic [7:0]  ramsz_q, ramsz_d;
  logic        ovf_q, ovf_d;

  logic                           in_range;
  logic                           in_logo;
  logic [chc_pkg::POS_W-1:0]      logo_off;
  logic [chc_pkg::LOGO_IDX_W-1:0] logo_idx;
  logic                           short_img;

  assign in_range = pos_q < chc_pkg::MAX_POS;
  assign in_logo  = (pos_q >= chc_pkg::LOGO_FIRST) && (pos_q <= chc_pkg::LOGO_LAST);
  assign logo_off = pos_q - chc_pkg::LOGO_FIRST;
  assign logo_idx = logo_off[chc_pkg::LOGO_IDX_W-1:0];

  always_comb begin
    pos_d        = pos_q;
    logo_match_d = logo_match_q;
    hdr_acc_d    = hdr_acc_q;
    glb_acc_d    = glb_acc_q;
    hdr_sum_d    = hdr_sum_q;
    glb_sum_d    = glb_sum_q;
    model_d      = model_q;
    cart_d       = cart_q;
    romsz_d      = romsz_q;
    ramsz_d      = ramsz_q;
    ovf_d        = ovf_q;
    if (in_range) begin
      pos_d = pos_q + chc_pkg::POS_W'(1);
      if (in_logo && (byte_i != chc_pkg::LOGO_TABLE[logo_idx])) begin
        logo_match_d = 1'b0;
      end
      if ((pos_q >= chc_pkg::HDR_FIRST) && (pos_q <= chc_pkg::HDR_LAST)) begin
        hdr_acc_d = hdr_acc_q - byte_i - 8'd1;
      end
      if (pos_q == chc_pkg::HDR_SUM_ADDR) begin
        hdr_sum_d = byte_i;
      end
      // The stored checksum bytes stay out of the running sum
      if (pos_q == chc_pkg::GLB_HI_ADDR) begin
        glb_sum_d = {byte_i, glb_sum_q[7:0]};
      end else if (pos_q == chc_pkg::GLB_LO_ADDR) begin
        glb_sum_d = {glb_sum_q[15:8], byte_i};
      end else begin
        glb_acc_d = glb_acc_q + {8'd0, byte_i};
      end
      if (pos_q == chc_pkg::MODEL_ADDR) model_d = byte_i;
      if (pos_q == chc_pkg::CART_ADDR)  cart_d  = byte_i;
      if (pos_q == chc_pkg::ROMSZ_ADDR) romsz_d = byte_i;
      if (pos_q == chc_pkg::RAMSZ_ADDR) ramsz_d = byte_i;
    end else begin
      ovf_d = 1'b1;
    end
  end

  // Result reflects the state including the current byte
  assign short_img = pos_d < chc_pkg::HEADER_END;

  always_comb begin
    res_o.logo_ok         = !short_img && logo_match_d;
    res_o.header_sum_ok   = !short_img && (hdr_acc_d == hdr_sum_d);
    res_o.global_sum_ok   = !short_img && (glb_acc_d == glb_sum_d);
    res_o.model_support   = chc_pkg::model_code(model_d);
    res_o.cart_kind       = cart_d;
    res_o.cart_kind_known = chc_pkg::cart_known(cart_d);
    res_o.rom_size_code   = romsz_d;
    res_o.rom_size_known  = chc_pkg::rom_size_known(romsz_d);
    res_o.ram_size_code   = ramsz_d;
    res_o.image_too_short = short_img;
    res_o.image_too_long  = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      logo_match_q <= 1'b1;
      hdr_acc_q    <= '0;
      glb_acc_q    <= '0;
      hdr_sum_q    <= '0;
      glb_sum_q    <= '0;
      model_q      <= '0;
      cart_q       <= '0;
      romsz_q      <= '0;
      ramsz_q      <= '0;
      ovf_q        <= 1'b0;
    end else if (step_i) begin
      if (final_i) begin
        // Image done: start over at address zero
        pos_q        <= '0;
        logo_match_q <= 1'b1;
        hdr_acc_q    <= '0;
        glb_acc_q    <= '0;
        hdr_sum_q    <= '0;
        glb_sum_q    <= '0;
        model_q      <= '0;
        cart_q       <= '0;
        romsz_q      <= '0;
        ramsz_q      <= '0;
        ovf_q        <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        logo_match_q <= logo_match_d;
        hdr_acc_q    <= hdr_acc_d;
        glb_acc_q    <= glb_acc_d;
        hdr_sum_q    <= hdr_sum_d;
        glb_sum_q    <= glb_sum_d;
        model_q      <= model_d;
        cart_q       <= cart_d;
        romsz_q      <= romsz_d;
        ramsz_q      <= ramsz_d;
        ovf_q        <= ovf_d;
      end
    end
  end

endmodule

/* sv/cartridge_header_checker_top.sv */
// Top level: input register, header state update and result register.
// A final byte passes the input register, then the header state update into the result register.
// Throughput: one byte per cycle; the input side stalls only while a final byte
// waits for the result register to free up.
// Reset: asynchronous, active low; clears all pipeline valids and the
// per-image state, so the next byte is address zero.
module cartridge_header_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rom_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       logo_ok_o,
  output logic       header_sum_ok_o,
  output logic       global_sum_ok_o,
  output logic [1:0] model_support_o,
  output logic [7:0] cart_kind_o,
  output logic       cart_kind_known_o,
  output logic [7:0] rom_size_code_o,
  output logic       rom_size_known_o,
  output logic [7:0] ram_size_code_o,
  output logic       image_too_short_o,
  output logic       image_too_long_o
);

  logic             s1_valid_q, s1_valid_d;
  logic [7:0]       s1_byte_q;
  logic             s1_final_q;
  logic             out_valid_q, out_valid_d;
  chc_pkg::result_t res_q;
  chc_pkg::result_t res_next;

  logic in_xfer;
  logic out_free;
  logic s1_advance;
  logic out_load;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  // Non-final bytes never need the result register
  assign s1_advance = s1_valid_q && (!s1_final_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign out_load   = s1_advance && s1_final_q;

  assign s1_valid_d  = in_xfer ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q  <= rom_byte_i;
      s1_final_q <= final_byte_i;
    end
    if (out_load) begin
      res_q <= res_next;
    end
  end

  chc_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_advance),
    .byte_i  (s1_byte_q),
    .final_i (s1_final_q),
    .res_o   (res_next)
  );

  assign out_valid_o       = out_valid_q;
  assign logo_ok_o         = res_q.logo_ok;
  assign header_sum_ok_o   = res_q.header_sum_ok;
  assign global_sum_ok_o   = res_q.global_sum_ok;
  assign model_support_o   = res_q.model_support;
  assign cart_kind_o       = res_q.cart_kind;
  assign cart_kind_known_o = res_q.cart_kind_known;
  assign rom_size_code_o   = res_q.rom_size_code;
  assign rom_size_known_o  = res_q.rom_size_known;
  assign ram_size_code_o   = res_q.ram_size_code;
  assign image_too_short_o = res_q.image_too_short;
  assign image_too_long_o  = res_q.image_too_long;

`ifndef SYNTHESIS
  a_final_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("final byte step did not load a result");

  a_stall_only_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_final_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked final byte");

  a_short_no_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.image_too_short) |->
      !(res_q.logo_ok || res_q.header_sum_ok || res_q.global_sum_ok))
    else $error("short image reported a passing check");

  a_model_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.model_support != 2'd3))
    else $error("model support code out of range");
`endif

endmodule

/* sim/tb.sv */
// Self-checking testbench for cartridge_header_checker_top: streams ROM images, checks reports.
module tb;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rom_beat_t;

  typedef enum int {FLAW_NONE, FLAW_LOGO, FLAW_HDR_SUM, FLAW_GLB_SUM, FLAW_BODY} flaw_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  localparam int unsigned ADDR_LOGO_FIRST = 'h104;
  localparam int unsigned ADDR_LOGO_LAST  = 'h133;
  localparam int unsigned ADDR_HDR_FIRST  = 'h134;
  localparam int unsigned ADDR_HDR_LAST   = 'h14C;
  localparam int unsigned ADDR_HDR_SUM    = 'h14D;
  localparam int unsigned ADDR_GLB_HI     = 'h14E;
  localparam int unsigned ADDR_GLB_LO     = 'h14F;
  localparam int unsigned ADDR_HEADER_END = 'h150;
  localparam int unsigned ADDR_MODEL      = 'h143;
  localparam int unsigned ADDR_CART       = 'h147;
  localparam int unsigned ADDR_ROMSZ      = 'h148;
  localparam int unsigned ADDR_RAMSZ      = 'h149;
  localparam int unsigned LOGO_BYTES      = 48;

  localparam logic [7:0] MODEL_BYTE_DUAL  = 8'h80;
  localparam logic [7:0] MODEL_BYTE_COLOR = 8'hC0;

  localparam logic [383:0] LOGO_BITS = {
    64'hCEED6666CC0D000B, 64'h03730083000C000D, 64'h0008111F8889000E,
    64'hDCCC6EE6DDDDD999, 64'hBBBB67636E0EECCC, 64'hDDDC999FBBB9333E
  };

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned QUEUE_DEPTH    = 512;
  localparam int unsigned ITEM_TARGET    = 1450;
  localparam int unsigned SECOND_HOLD_AT = 1400;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] rom_byte_i   = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic       logo_ok_o;
  logic       header_sum_ok_o;
  logic       global_sum_ok_o;
  logic [1:0] model_support_o;
  logic [7:0] cart_kind_o;
  logic       cart_kind_known_o;
  logic [7:0] rom_size_code_o;
  logic       rom_size_known_o;
  logic [7:0] ram_size_code_o;
  logic       image_too_short_o;
  logic       image_too_long_o;

  cartridge_header_checker_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rom_byte_i        (rom_byte_i),
    .final_byte_i      (final_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .logo_ok_o         (logo_ok_o),
    .header_sum_ok_o   (header_sum_ok_o),
    .global_sum_ok_o   (global_sum_ok_o),
    .model_support_o   (model_support_o),
    .cart_kind_o       (cart_kind_o),
    .cart_kind_known_o (cart_kind_known_o),
    .rom_size_code_o   (rom_size_code_o),
    .rom_size_known_o  (rom_size_known_o),
    .ram_size_code_o   (ram_size_code_o),
    .image_too_short_o (image_too_short_o),
    .image_too_long_o  (image_too_long_o)
  );

  rom_beat_t         pending_bytes [$];
  chc_pkg::result_t  header_reports_due [$];
  logic [7:0]        image_bytes [$];

  // Predicted checker state
  int unsigned img_pos;
  logic        logo_good;
  logic [7:0]  hdr_acc;
  logic [15:0] glb_acc;
  logic [7:0]  hdr_stored;
  logic [15:0] glb_stored;
  logic [7:0]  model_seen;
  logic [7:0]  cart_seen;
  logic [7:0]  romsz_seen;
  logic [7:0]  ramsz_seen;
  logic        overflow_seen;

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned images_sent = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned mode_left;
  stall_mode_e stall_mode;
  rom_beat_t   next_beat;

  function automatic logic [7:0] logo_byte(input int unsigned idx);
    return LOGO_BITS[383 - 8 * idx -: 8];
  endfunction

  function automatic logic cart_code_known(input logic [7:0] c);
    return (c <= 8'h03) || (c == 8'h05) || (c == 8'h06) || (c == 8'h08) || (c == 8'h09) ||
           (c >= 8'h0B && c <= 8'h0D) || (c >= 8'h0F && c <= 8'h13) ||
           (c >= 8'h19 && c <= 8'h1F) || (c >= 8'hFD);
  endfunction

  function automatic void clear_image();
    img_pos       = 0;
    logo_good     = 1'b1;
    hdr_acc       = 8'h00;
    glb_acc       = 16'h0000;
    hdr_stored    = 8'h00;
    glb_stored    = 16'h0000;
    model_seen    = 8'h00;
    cart_seen     = 8'h00;
    romsz_seen    = 8'h00;
    ramsz_seen    = 8'h00;
    overflow_seen = 1'b0;
  endfunction

  // Advance the predicted state by one accepted byte; queue a report on the final one.
  function automatic void track_rom_byte(input logic [7:0] b, input logic last);
    chc_pkg::result_t rep;
    logic             short_img;
    if (img_pos < chc_pkg::MAX_IMAGE_BYTES) begin
      if (img_pos >= ADDR_LOGO_FIRST && img_pos <= ADDR_LOGO_LAST &&
          b != logo_byte(img_pos - ADDR_LOGO_FIRST)) logo_good = 1'b0;
      if (img_pos >= ADDR_HDR_FIRST && img_pos <= ADDR_HDR_LAST) hdr_acc = hdr_acc - b - 8'd1;
      if (img_pos == ADDR_HDR_SUM) hdr_stored = b;
      if (img_pos == ADDR_GLB_HI) glb_stored[15:8] = b;
      else if (img_pos == ADDR_GLB_LO) glb_stored[7:0] = b;
      else glb_acc = glb_acc + {8'h00, b};
      if (img_pos == ADDR_MODEL) model_seen = b;
      if (img_pos == ADDR_CART) cart_seen = b;
      if (img_pos == ADDR_ROMSZ) romsz_seen = b;
      if (img_pos == ADDR_RAMSZ) ramsz_seen = b;
      img_pos++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (last) begin
      short_img           = (img_pos < ADDR_HEADER_END);
      rep.logo_ok         = short_img ? 1'b0 : logo_good;
      rep.header_sum_ok   = short_img ? 1'b0 : (hdr_acc == hdr_stored);
      rep.global_sum_ok   = short_img ? 1'b0 : (glb_acc == glb_stored);
      rep.model_support   = (model_seen == MODEL_BYTE_DUAL)  ? chc_pkg::MODEL_DUAL :
                            (model_seen == MODEL_BYTE_COLOR) ? chc_pkg::MODEL_COLOR_ONLY :
                                                               chc_pkg::MODEL_ORIG_ONLY;
      rep.cart_kind       = cart_seen;
      rep.cart_kind_known = cart_code_known(cart_seen);
      rep.rom_size_code   = romsz_seen;
      rep.rom_size_known  = (romsz_seen <= 8'h06) || (romsz_seen >= 8'h52 && romsz_seen <= 8'h54);
      rep.ram_size_code   = ramsz_seen;
      rep.image_too_short = short_img;
      rep.image_too_long  = overflow_seen;
      header_reports_due.push_back(rep);
      clear_image();
    end
  endfunction

  function automatic string describe(input chc_pkg::result_t r);
    return $sformatf("logo=%0d hdr=%0d glb=%0d model=%0d cart=%h/%0d rom=%h/%0d ram=%h short=%0d long=%0d",
                     r.logo_ok, r.header_sum_ok, r.global_sum_ok, r.model_support,
                     r.cart_kind, r.cart_kind_known, r.rom_size_code, r.rom_size_known,
                     r.ram_size_code, r.image_too_short, r.image_too_long);
  endfunction

  // Image construction

  function automatic void put_byte(input int unsigned idx, input logic [7:0] val);
    if (idx < image_bytes.size()) image_bytes[idx] = val;
  endfunction

  function automatic void flip_bit(input int unsigned idx);
    if (idx < image_bytes.size()) image_bytes[idx] = image_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
  endfunction

  // Well-formed header with random body; each flaw breaks one check, but a header-byte flaw breaks both sums.
  task automatic build_image(input int unsigned len, input logic [7:0] model, input logic [7:0] cart,
                             input logic [7:0] romsz, input logic [7:0] ramsz, input flaw_e flaw);
    int unsigned k;
    logic [7:0]  hsum;
    logic [15:0] gsum;
    image_bytes.delete();
    for (k = 0; k < len; k++) image_bytes.push_back(8'($urandom));
    for (k = 0; k < LOGO_BYTES; k++) put_byte(ADDR_LOGO_FIRST + k, logo_byte(k));
    put_byte(ADDR_MODEL, model);
    put_byte(ADDR_CART, cart);
    put_byte(ADDR_ROMSZ, romsz);
    put_byte(ADDR_RAMSZ, ramsz);
    if (flaw == FLAW_LOGO) flip_bit(ADDR_LOGO_FIRST + $urandom_range(0, LOGO_BYTES - 1));
    hsum = 8'h00;
    for (k = ADDR_HDR_FIRST; k <= ADDR_HDR_LAST && k < len; k++) hsum = hsum - image_bytes[k] - 8'd1;
    put_byte(ADDR_HDR_SUM, hsum);
    if (flaw == FLAW_HDR_SUM) flip_bit(ADDR_HDR_SUM);
    gsum = 16'h0000;
    for (k = 0; k < len; k++)
      if (k != ADDR_GLB_HI && k != ADDR_GLB_LO) gsum = gsum + {8'h00, image_bytes[k]};
    put_byte(ADDR_GLB_HI, gsum[15:8]);
    put_byte(ADDR_GLB_LO, gsum[7:0]);
    if (flaw == FLAW_GLB_SUM) flip_bit($urandom_range(0, 1) ? ADDR_GLB_HI : ADDR_GLB_LO);
    if (flaw == FLAW_BODY) flip_bit($urandom_range(ADDR_HDR_FIRST, ADDR_HDR_LAST));
  endtask

  // A negative fill value gives random bytes.
  task automatic fill_image(input int unsigned len, input int fill);
    int unsigned k;
    image_bytes.delete();
    for (k = 0; k < len; k++) image_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  task automatic push_beat(input logic [7:0] data, input logic last);
    rom_beat_t beat;
    while (pending_bytes.size() >= QUEUE_DEPTH) @(posedge clk_i);
    beat.data = data;
    beat.last = last;
    pending_bytes.push_back(beat);
    items_sent++;
  endtask

  task automatic send_image(input bit ends);
    int unsigned k;
    for (k = 0; k < image_bytes.size(); k++)
      push_beat(image_bytes[k], ends && (k == image_bytes.size() - 1));
    if (ends) images_sent++;
  endtask

  task automatic send_tiny_images(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      fill_image($urandom_range(1, 3), -1);
      send_image(1'b1);
    end
  endtask

  // Stop offering bytes until every expected report has come back.
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (header_reports_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_model();
    case ($urandom_range(0, 2))
      0:       return MODEL_BYTE_DUAL;
      1:       return MODEL_BYTE_COLOR;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_cart();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_romsz();
    case ($urandom_range(0, 3))
      0, 1:    return 8'($urandom_range(0, 7));
      2:       return 8'($urandom_range(8'h50, 8'h56));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sender: bursts of transfers with random gaps; hold the payload while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      rom_byte_i   <= 8'h00;
      final_byte_i <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
      clear_image();
    end else begin
      if (in_valid_i && !in_stall_o) track_rom_byte(rom_byte_i, final_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_beat = pending_bytes.pop_front();
          in_valid_i   <= 1'b1;
          rom_byte_i   <= next_beat.data;
          final_byte_i <= next_beat.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern of its own, plus long holds on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      holds_done  = 0;
      hold_left   = 0;
      mode_left   = 0;
      stall_mode  = STALL_NONE;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 4) == 0);
        STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 4) != 0);
        STALL_PERIODIC: out_stall_i <= (cycle_count[2:0] < 3'd3);
        default:        out_stall_i <= 1'b0;
      endcase
    end
  end

  // Report checker
  always @(posedge clk_i) begin
    chc_pkg::result_t got;
    chc_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.logo_ok         = logo_ok_o;
      got.header_sum_ok   = header_sum_ok_o;
      got.global_sum_ok   = global_sum_ok_o;
      got.model_support   = model_support_o;
      got.cart_kind       = cart_kind_o;
      got.cart_kind_known = cart_kind_known_o;
      got.rom_size_code   = rom_size_code_o;
      got.rom_size_known  = rom_size_known_o;
      got.ram_size_code   = ram_size_code_o;
      got.image_too_short = image_too_short_o;
      got.image_too_long  = image_too_long_o;
      if (header_reports_due.size() == 0) begin
        if (mismatches < 10) $display("cycle %0d: unexpected report: %s", cycle_count, describe(got));
        mismatches++;
      end else begin
        want = header_reports_due.pop_front();
        if (got.logo_ok !== want.logo_ok || got.header_sum_ok !== want.header_sum_ok ||
            got.global_sum_ok !== want.global_sum_ok ||
            got.model_support !== want.model_support || got.cart_kind !== want.cart_kind ||
            got.cart_kind_known !== want.cart_kind_known ||
            got.rom_size_code !== want.rom_size_code ||
            got.rom_size_known !== want.rom_size_known ||
            got.ram_size_code !== want.ram_size_code ||
            got.image_too_short !== want.image_too_short ||
            got.image_too_long !== want.image_too_long) begin
          if (mismatches < 10) begin
            $display("cycle %0d: report mismatch", cycle_count);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned len;
    bit          second_hold;
    second_hold = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one-byte images, then full images that pass or break one check each
    fill_image(1, 8'h00); send_image(1'b1);
    fill_image(1, 8'hFF); send_image(1'b1);
    build_image(ADDR_HEADER_END, MODEL_BYTE_DUAL, 8'h13, 8'h52, 8'h02, FLAW_NONE);
    send_image(1'b1);
    build_image(ADDR_HEADER_END + 1, MODEL_BYTE_COLOR, 8'hFF, 8'h54, 8'hFF, FLAW_LOGO);
    send_image(1'b1);
    build_image(ADDR_HEADER_END, 8'h7F, 8'h1B, 8'h07, 8'h00, FLAW_HDR_SUM);
    send_image(1'b1);
    build_image(ADDR_HEADER_END + 2, 8'hC1, 8'h20, 8'h55, 8'h80, FLAW_GLB_SUM);
    send_image(1'b1);
    drain();

    // Random: long receiver hold while tiny images pile up behind it
    hold_requests++;
    send_tiny_images(8);
    while (items_sent < ITEM_TARGET) begin
      if (!second_hold && items_sent >= SECOND_HOLD_AT) begin
        second_hold = 1'b1;
        drain();
        hold_requests++;
        send_tiny_images(6);
      end
      len = $urandom_range(1, 16);
      if ($urandom_range(0, 1)) fill_image(len, -1);
      else build_image(len, pick_model(), pick_cart(), pick_romsz(), 8'($urandom), FLAW_NONE);
      send_image(1'b1);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && header_reports_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
